FILE: rtl/sha_pkg.sv
// sha_pkg: constants, types and round functions for the SHA-256 stream hasher
// no dependencies
package sha_pkg;

    localparam logic [31:0] C_H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] C_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] C_PAD_MARK = 8'h80;
    localparam logic [7:0] C_PAD_ZERO = 8'h00;
    localparam logic [5:0] C_LEN_POS  = 6'd56;

    typedef enum logic [3:0] {
        S_IDLE,    // take next item
        S_PUT,     // read-modify-write one byte into block memory
        S_PAD,     // write one pad byte
        S_LEN_HI,  // write length high word
        S_LEN_LO,  // write length low word
        S_CINIT,   // load working vars from hash
        S_ROUND,   // 64 rounds
        S_CFOLD,   // add working vars into hash
        S_OUT      // emit digest words
    } t_state;

    // what to do after a compression finishes
    typedef struct packed {
        logic pad_pending; // length words written, last block
        logic eom;         // message ends with this item
    } t_flags;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

FILE: rtl/sha_sched.sv
// sha_sched: message schedule held in a 16-word memory, one word per round
// depends on sha_pkg
module sha_sched
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_wr_en,     // byte/length writes from the packer
    input  logic [3:0]  i_wr_addr,
    input  logic [31:0] i_wr_data,
    input  logic [3:0]  i_rd_addr,   // packer read address
    output logic [31:0] o_rd_data,
    input  logic        i_run,       // round engine active
    input  logic [5:0]  i_round,
    output logic [31:0] o_w
);

    logic [31:0] r_mem [16];
    // shift window of the schedule: w[t-16..t-1]
    logic [31:0] r_win [16];
    logic [31:0] r_rd_w;
    logic [3:0]  rd_w_addr;
    logic [31:0] w_new;

    // fetch one word ahead: word 0 during the load cycle, then the next round's word
    assign rd_w_addr = i_run ? (i_round[3:0] + 4'd1) : 4'd0;

    // rounds below 16 read block words; later ones extend the window
    always_comb begin
        w_new = r_win[0] + ssig0(r_win[1]) + r_win[9] + ssig1(r_win[14]);
        if (i_round < 6'd16) begin
            o_w = r_rd_w;
        end else begin
            o_w = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
        r_rd_w    <= r_mem[rd_w_addr];
        if (i_run) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= o_w;
        end
    end

endmodule

FILE: rtl/sha256_stream_hasher_unit.sv
// sha256_stream_hasher_unit: byte-serial SHA-256 with padding and digest output
// depends on sha_pkg and sha_sched
// a byte is a block memory read then write; a full block adds a compression
// (load, 64 rounds, fold); end of message adds padding bytes, 2 length writes,
// 1-2 compressions and 8 output words
// reset returns hash to the initial values and clears fill and length
module sha256_stream_hasher_unit
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_state r_state, n_state;
    t_flags r_flags;
    logic [5:0]  r_fill;
    logic [60:0] r_len;
    logic [7:0]  r_byte;
    logic [5:0]  r_round;
    logic [2:0]  r_oidx;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic        r_fwd_we;
    logic [3:0]  r_fwd_wa;
    logic [31:0] r_fwd_wd;

    logic        mem_we;
    logic [3:0]  mem_wa;
    logic [31:0] mem_wd;
    logic [31:0] mem_rd;
    logic [31:0] w_t;
    logic [31:0] merged;
    logic [63:0] bits;

    sha_sched u_sched (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_wa),
        .i_wr_data (mem_wd),
        .i_rd_addr (r_fill[5:2]),
        .o_rd_data (mem_rd),
        .i_run     (r_state == S_ROUND),
        .i_round   (r_round),
        .o_w       (w_t)
    );

    assign bits = {r_len, 3'b000};

    // byte lands in its lane; first byte of a word clears the rest
    // the word written last cycle is not yet in the registered read
    always_comb begin
        if (r_fill[1:0] == 2'd0) begin
            merged = 32'd0;
        end else if (r_fwd_we && r_fwd_wa == r_fill[5:2]) begin
            merged = r_fwd_wd;
        end else begin
            merged = mem_rd;
        end
        case (r_fill[1:0])
            2'd0:    merged[31:24] = r_byte;
            2'd1:    merged[23:16] = r_byte;
            2'd2:    merged[15:8]  = r_byte;
            default: merged[7:0]   = r_byte;
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_fill[5:2];
        mem_wd = merged;
        case (r_state)
            S_PUT, S_PAD: mem_we = 1'b1;
            S_LEN_HI: begin
                mem_we = 1'b1;
                mem_wa = 4'd14;
                mem_wd = bits[63:32];
            end
            S_LEN_LO: begin
                mem_we = 1'b1;
                mem_wa = 4'd15;
                mem_wd = bits[31:0];
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_has_byte) begin
                        n_state = S_PUT;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PUT, S_PAD: begin
                if (r_fill == 6'd63) begin
                    n_state = S_CINIT;
                end else if (r_state == S_PUT && !r_flags.eom) begin
                    n_state = S_IDLE;
                end else if (r_state == S_PAD && r_fill == C_LEN_POS - 6'd1) begin
                    n_state = S_LEN_HI;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_LEN_HI: n_state = S_LEN_LO;
            S_LEN_LO: n_state = S_CINIT;
            S_CINIT:  n_state = S_ROUND;
            S_ROUND:  if (r_round == 6'd63) n_state = S_CFOLD;
            S_CFOLD: begin
                if (!r_flags.eom) begin
                    n_state = S_IDLE;
                end else if (r_fill == C_LEN_POS) begin
                    n_state = S_LEN_HI;
                end else if (r_flags.pad_pending && r_fill == 6'd0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: if (i_ready && r_oidx == 3'd7) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready       = (r_state == S_IDLE);
        o_valid       = (r_state == S_OUT);
        o_digest_word = r_h[r_oidx];
        o_word_index  = r_oidx;
        o_last_word   = (r_oidx == 3'd7);
    end

    logic [31:0] t1, t2;
    always_comb begin
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + C_K[r_round] + w_t;
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_flags  <= '0;
            r_fill   <= '0;
            r_len    <= '0;
            r_round  <= '0;
            r_oidx   <= '0;
            r_fwd_we <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= C_H_INIT[i];
        end else begin
            r_state  <= n_state;
            r_fwd_we <= mem_we;
            r_fwd_wa <= mem_wa;
            r_fwd_wd <= mem_wd;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_byte  <= i_has_byte ? i_data_byte : C_PAD_MARK;
                        r_flags <= '{pad_pending: 1'b0, eom: i_end_of_message};
                        if (i_has_byte) r_len <= r_len + 61'd1;
                    end
                end
                S_PUT, S_PAD: begin
                    r_fill <= r_fill + 6'd1;
                    // the mark goes first, zeros follow
                    if (r_state == S_PAD) begin
                        r_byte <= C_PAD_ZERO;
                    end else begin
                        r_byte <= C_PAD_MARK;
                    end
                end
                S_LEN_LO: begin
                    r_fill <= '0;
                    r_flags.pad_pending <= 1'b1;
                end
                S_CINIT: begin
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_round <= '0;
                end
                S_ROUND: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_round <= r_round + 6'd1;
                end
                S_CFOLD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_oidx <= '0;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= C_H_INIT[i];
                            r_fill  <= '0;
                            r_len   <= '0;
                            r_flags <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // the padding never leaves the block past the length slot
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN_HI) |-> (r_fill == C_LEN_POS))
        else $error("length written at wrong fill");
    // digest words only leave with a finished message
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> r_flags.eom && r_fill == 6'd0)
        else $error("digest without end of message");
    // rounds start from zero after load
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CINIT) |=> (r_state == S_ROUND && r_round == 6'd0))
        else $error("round counter not cleared");

endmodule

FILE: tb/tb.sv
// tb: self-checking bench for sha256_stream_hasher_unit, byte stream in, digest words out
// depends on sha_pkg (round constants, initial hash) and the rtl top level
`timescale 1ns / 100ps

module tb
    import sha_pkg::*;
;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_has_byte = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha256_stream_hasher_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_data_byte(i_data_byte), .i_has_byte(i_has_byte),
        .i_end_of_message(i_end_of_message),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       eom;
    } t_byte_item;

    // shadow hasher state
    logic [31:0] hash_st [8];
    logic [31:0] blk_st [16];
    logic [5:0]  fill_st;
    logic [60:0] len_st;

    t_digest_word digest_q [$];
    int errors = 0;
    int digests_seen = 0;
    int bytes_sent = 0;
    bit quiet_tail = 1'b0;
    bit held_off = 1'b0;

    function automatic logic [31:0] rr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, p, q;
        for (int i = 0; i < 16; i++) w[i] = blk_st[i];
        for (int i = 16; i < 64; i++) begin
            p = w[i-15];
            q = w[i-2];
            w[i] = w[i-16] + (rr(p, 7) ^ rr(p, 18) ^ (p >> 3)) + w[i-7]
                 + (rr(q, 17) ^ rr(q, 19) ^ (q >> 10));
        end
        for (int i = 0; i < 8; i++) v[i] = hash_st[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + C_K[i] + w[i];
            t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_st[i] = hash_st[i] + v[i];
    endtask

    task automatic load_byte(logic [7:0] b);
        logic [3:0] wi;
        wi = fill_st[5:2];
        if (fill_st[1:0] == 2'd0) blk_st[wi] = '0;
        blk_st[wi] = blk_st[wi] | (32'(b) << ((3 - fill_st[1:0]) * 8));
        fill_st = fill_st + 6'd1;
        if (fill_st == 6'd0) compress_block();
    endtask

    task automatic hasher_restart();
        for (int i = 0; i < 8; i++) hash_st[i] = C_H_INIT[i];
        for (int i = 0; i < 16; i++) blk_st[i] = '0;
        fill_st = '0;
        len_st = '0;
    endtask

    task automatic predict_item(t_byte_item it);
        logic [63:0] bits;
        t_digest_word dw;
        if (it.has) begin
            len_st = len_st + 61'd1;
            load_byte(it.data);
        end
        if (it.eom) begin
            bits = {len_st, 3'b000};
            load_byte(C_PAD_MARK);
            while (fill_st != C_LEN_POS) load_byte(C_PAD_ZERO);
            blk_st[14] = bits[63:32];
            blk_st[15] = bits[31:0];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                dw.word = hash_st[i];
                dw.idx = 3'(i);
                dw.last = (i == 7);
                digest_q.push_back(dw);
            end
            hasher_restart();
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    // typed-in digests of "" and "abc" on the first words
    logic [31:0] known_first [$];

    // output side: random stalls, compare every transfer
    always @(posedge i_clk) begin
        t_digest_word e;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (digest_q.size() == 0) begin
                    report_mismatch("unexpected word", o_digest_word, 32'h0);
                end else begin
                    e = digest_q.pop_front();
                    if (o_digest_word !== e.word)
                        report_mismatch("digest_word", o_digest_word, e.word);
                    if (o_word_index !== e.idx)
                        report_mismatch("word_index", 32'(o_word_index), 32'(e.idx));
                    if (o_last_word !== e.last)
                        report_mismatch("last_word", 32'(o_last_word), 32'(e.last));
                    if (o_word_index == 3'd0 && known_first.size() > 0) begin
                        if (o_digest_word !== known_first[0])
                            report_mismatch("known digest", o_digest_word, known_first[0]);
                        void'(known_first.pop_front());
                    end
                    if (o_last_word) digests_seen++;
                end
            end
            i_ready <= quiet_tail ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // valid stays up from one transfer into the next unless a gap is taken
    task automatic send_item(t_byte_item it);
        int gap;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= it.data;
        i_has_byte <= it.has;
        i_end_of_message <= it.eom;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_item(it);
        if (it.has) bytes_sent++;
    endtask

    t_byte_item directed [$];
    t_byte_item it;
    int msg_len;

    initial begin
        hasher_restart();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, "abc", idle item, all-ones and zero bytes in one message
        directed.push_back('{8'h00, 1'b0, 1'b1});
        known_first.push_back(32'he3b0c442);
        directed.push_back('{8'h61, 1'b1, 1'b0});
        directed.push_back('{8'h00, 1'b0, 1'b0});
        directed.push_back('{8'h62, 1'b1, 1'b0});
        directed.push_back('{8'h63, 1'b1, 1'b1});
        known_first.push_back(32'hba7816bf);
        directed.push_back('{8'hff, 1'b1, 1'b0});
        directed.push_back('{8'h00, 1'b1, 1'b0});
        directed.push_back('{8'h55, 1'b1, 1'b0});
        directed.push_back('{8'haa, 1'b1, 1'b0});
        directed.push_back('{8'h00, 1'b0, 1'b1});
        foreach (directed[i]) send_item(directed[i]);

        // random messages; lengths near 55/56/64 straddle the extra padding block (56 to 63 need it)
        while (bytes_sent < 200) begin
            case ($urandom_range(0, 3))
                0: msg_len = $urandom_range(0, 8);
                1: msg_len = $urandom_range(54, 57);
                2: msg_len = $urandom_range(63, 65);
                default: msg_len = $urandom_range(0, 30);
            endcase
            for (int n = 0; n < msg_len; n++) begin
                it.data = 8'($urandom());
                it.has = 1'b1;
                it.eom = (n == msg_len - 1) && ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 9) == 0) send_item('{8'($urandom()), 1'b0, 1'b0});
                send_item(it);
            end
            if (msg_len == 0 || !it.eom) send_item('{8'($urandom()), 1'b0, 1'b1});
            if (bytes_sent > 80 && !held_off) begin
                // hold off until every digest word has drained
                held_off = 1'b1;
                if (digest_q.size() != 0) begin
                    i_valid <= 1'b0;
                    while (digest_q.size() != 0) @(posedge i_clk);
                end
            end
            if (bytes_sent > 160) quiet_tail = 1'b1;
        end

        i_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d message bytes and %0d digests, including empty and padding-edge",
                 bytes_sent, digests_seen);
        if (errors == 0 && known_first.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout with %0d words outstanding", digest_q.size());
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
